[src/utf8_stream_decoder_assert.svh]
// assertion macros used by the decoder top level
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTF8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder assertion failed");

// next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder assertion failed");

`endif

[src/utf8d_pkg.sv]
// types and constants of the utf-8 stream decoder
package utf8d_pkg;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;

    // sequence class codes
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] partial;
        logic [1:0]  seq_class;
    } state_t;

    typedef struct packed {
        logic [1:0]  count;
        logic [20:0] cp0;
        logic [20:0] cp1;
        state_t      next_state;
    } decode_t;

    // smallest value a sequence of the given class may encode
    function automatic logic [20:0] class_min(input logic [1:0] seq_class);
        logic [20:0] m;
        case (seq_class)
            CLASS_TWO:   m = 21'h000080;
            CLASS_THREE: m = 21'h000800;
            CLASS_FOUR:  m = 21'h010000;
            default:     m = 21'h000000;
        endcase
        return m;
    endfunction

endpackage

[src/utf8d_if.sv]
// byte and code point channel interfaces
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        last_of_run;
    logic        text_done;

    modport source (output valid, output code_point, output last_of_run, output text_done,
                    input ready);
    modport sink (input valid, input code_point, input last_of_run, input text_done,
                  output ready);
endinterface

[src/utf8d_decode.sv]
// combinational decode of one byte against the open sequence state
module utf8d_decode (
    input  utf8d_pkg::state_t  state,
    input  logic [7:0]         byte_value,
    input  logic               final_byte,
    output utf8d_pkg::decode_t result
);

    always_comb
    begin
        utf8d_pkg::state_t st;
        logic [1:0]        cnt;
        logic [20:0]       cp0;
        logic [20:0]       cp1;
        logic [20:0]       val;
        logic [1:0]        left;
        logic              is_cont;
        logic              do_lead;

        st      = state;
        cnt     = 2'd0;
        cp0     = '0;
        cp1     = '0;
        val     = {state.partial[14:0], byte_value[5:0]};
        left    = state.pending - 2'd1;
        is_cont = (byte_value[7:6] == 2'b10);
        do_lead = 1'b0;

        if (state.pending != 2'd0)
        begin
            if (is_cont)
            begin
                st.pending = left;
                st.partial = val;
                if (left == 2'd0)
                begin
                    if (val < utf8d_pkg::class_min(state.seq_class) ||
                        val > utf8d_pkg::MAX_CODE ||
                        (val >= utf8d_pkg::SURR_LO && val <= utf8d_pkg::SURR_HI))
                    begin
                        cp0 = utf8d_pkg::REPLACEMENT;
                    end
                    else
                    begin
                        cp0 = val;
                    end
                    cnt = 2'd1;
                    st  = '0;
                end
            end
            else
            begin
                // broken sequence: replacement, then the byte starts over
                cp0     = utf8d_pkg::REPLACEMENT;
                cnt     = 2'd1;
                st      = '0;
                do_lead = 1'b1;
            end
        end
        else
        begin
            do_lead = 1'b1;
        end

        if (do_lead)
        begin
            if (byte_value[7] == 1'b0)
            begin
                if (cnt == 2'd0) cp0 = {13'd0, byte_value};
                else             cp1 = {13'd0, byte_value};
                cnt = cnt + 2'd1;
            end
            else if (byte_value[7:5] == 3'b110)
            begin
                st.pending   = 2'd1;
                st.seq_class = utf8d_pkg::CLASS_TWO;
                st.partial   = {16'd0, byte_value[4:0]};
            end
            else if (byte_value[7:4] == 4'b1110)
            begin
                st.pending   = 2'd2;
                st.seq_class = utf8d_pkg::CLASS_THREE;
                st.partial   = {17'd0, byte_value[3:0]};
            end
            else if (byte_value[7:3] == 5'b11110)
            begin
                st.pending   = 2'd3;
                st.seq_class = utf8d_pkg::CLASS_FOUR;
                st.partial   = {18'd0, byte_value[2:0]};
            end
            else
            begin
                if (cnt == 2'd0) cp0 = utf8d_pkg::REPLACEMENT;
                else             cp1 = utf8d_pkg::REPLACEMENT;
                cnt = cnt + 2'd1;
            end
        end

        if (final_byte)
        begin
            // sequence left open at the end of the text
            if (st.pending != 2'd0)
            begin
                if (cnt == 2'd0) cp0 = utf8d_pkg::REPLACEMENT;
                else             cp1 = utf8d_pkg::REPLACEMENT;
                cnt = cnt + 2'd1;
            end
            st = '0;
        end

        result.count      = cnt;
        result.cp0        = cp0;
        result.cp1        = cp1;
        result.next_state = st;
    end

endmodule

[src/utf8_stream_decoder.sv]
// utf-8 stream decoder top level
//
// byte_in takes one UTF-8 byte per transaction, with final_byte set on the
// last byte of a text. cp_out gives decoded code points, U+FFFD for any
// malformed input; last_of_run marks the last code point caused by a byte
// and text_done the last one of a text.
// a byte is held in an input register and decoded there against the open
// sequence state; its results pass one at a time into the output register.
// throughput: one byte per cycle while cp_out does not stall; a byte
// that causes two code points holds the input register until both have
// passed, one at a time, through the single output register.
// bytes inside a multi-byte sequence give no transaction on cp_out.
// a stall on cp_out holds the output register; the input register still
// drains bytes that give no result, and then byte_in.ready drops.
// reset empties both registers and closes any open sequence; after the
// final byte of a text the state closes again for the next text.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
    input  logic              clk,
    input  logic              rst_n,
    utf8d_byte_if.sink        byte_in,
    utf8d_cp_if.source        cp_out
);

    utf8d_pkg::state_t  state_reg, state_next;
    utf8d_pkg::decode_t dec;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_fin_reg;
    logic        phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [20:0] out_cp_reg;
    logic        out_last_reg;
    logic        out_done_reg;

    logic load_ok;
    logic has_out;
    logic last_emit;
    logic emit;
    logic consume;
    logic take;

    utf8d_decode u_decode (
        .state      (state_reg),
        .byte_value (in_byte_reg),
        .final_byte (in_fin_reg),
        .result     (dec)
    );

    assign load_ok   = !out_valid_reg || cp_out.ready;
    assign has_out   = (dec.count != 2'd0);
    assign last_emit = (dec.count == 2'd1) || phase_reg;
    assign emit      = in_valid_reg && has_out && load_ok;
    assign consume   = in_valid_reg && (!has_out || (load_ok && last_emit));
    assign take      = byte_in.valid && byte_in.ready;

    assign byte_in.ready      = !in_valid_reg || consume;
    assign cp_out.valid       = out_valid_reg;
    assign cp_out.code_point  = out_cp_reg;
    assign cp_out.last_of_run = out_last_reg;
    assign cp_out.text_done   = out_done_reg;

    always_comb
    begin
        state_next     = consume ? dec.next_state : state_reg;
        in_valid_next  = take || (in_valid_reg && !consume);
        phase_next     = phase_reg;
        if (emit && !last_emit)
        begin
            phase_next = 1'b1;
        end
        else if (consume)
        begin
            phase_next = 1'b0;
        end
        out_valid_next = emit || (out_valid_reg && !cp_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= byte_in.byte_value;
            in_fin_reg  <= byte_in.final_byte;
        end
        if (emit)
        begin
            out_cp_reg   <= phase_reg ? dec.cp1 : dec.cp0;
            out_last_reg <= last_emit;
            out_done_reg <= last_emit && in_fin_reg;
        end
    end

    // second result of a byte only while that byte is still held
    `UTF8D_ASSERT_SAME(a_phase_held, clk, rst_n, phase_reg, in_valid_reg && dec.count == 2'd2)
    // a closed sequence keeps no leftover bits or class
    `UTF8D_ASSERT_SAME(a_closed_clean, clk, rst_n, state_reg.pending == 2'd0,
                       state_reg.partial == 21'd0 && state_reg.seq_class == utf8d_pkg::CLASS_NONE)
    // end of text only on the last code point of its byte
    `UTF8D_ASSERT_SAME(a_done_last, clk, rst_n, out_valid_reg && out_done_reg, out_last_reg)
    // a final byte leaves no sequence open
    `UTF8D_ASSERT_NEXT(a_final_closes, clk, rst_n, consume && in_fin_reg,
                       state_reg.pending == 2'd0)

endmodule
